>>> hw/rtl/tcpu_pkg.sv
package tcpu_pkg;

   localparam int TCPU_REG_WIDTH = 8;
   localparam int TCPU_NUM_REGS  = 16;
   localparam int TCPU_INDEX_W   = 4;
   localparam int TCPU_IMM_W     = 8;
   localparam int TCPU_OUT_W     = 8;

   typedef enum logic [2:0] {
      OP_NOP  = 3'd0,
      OP_ADD  = 3'd1,
      OP_ADDI = 3'd2,
      OP_SUB  = 3'd3,
      OP_MOV  = 3'd4,
      OP_MOVI = 3'd5,
      OP_HALT = 3'd6
   } op_type;

   typedef struct packed {
      logic [2:0]              op;
      logic [TCPU_INDEX_W-1:0] dst_index;
      logic [TCPU_INDEX_W-1:0] src_index;
      logic [TCPU_IMM_W-1:0]   imm_value;
   } req_type;

   typedef struct packed {
      logic [TCPU_OUT_W-1:0] dst_value;
      logic                  zero_flag;
      logic                  carry_flag;
      logic                  halted;
   } rsp_type;

   typedef enum logic [0:0] {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic load;
      logic exec;
   } cmd_type;

   // index modulo the register count, by repeated compare and subtract
   function automatic logic [TCPU_INDEX_W-1:0] wrap_index(
      input logic [TCPU_INDEX_W-1:0] idx,
      input int unsigned             n
   );
      logic [TCPU_INDEX_W-1:0] v;
      v = idx;
      for (int i = 0; i < 8; i++) begin
         if (32'(v) >= n) begin
            v = v - TCPU_INDEX_W'(n);
         end
      end
      return v;
   endfunction

endpackage

>>> hw/rtl/tcpu_ram.sv
module tcpu_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   output logic [WIDTH-1:0]         rd_data_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_a_ff;
   logic [WIDTH-1:0] rd_data_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_a_ff <= mem[rd_addr_a];
      rd_data_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_data_a_ff;
   assign rd_data_b = rd_data_b_ff;

endmodule

>>> hw/rtl/tcpu_controller.sv
module tcpu_controller (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output tcpu_pkg::cmd_type cmd
);
   import tcpu_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      busy     = 1'b0;
      cmd.load = 1'b0;
      cmd.exec = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            cmd.load = start;
         end
         ST_EXEC: begin
            busy     = 1'b1;
            cmd.exec = 1'b1;
         end
         default: begin
            busy = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

>>> hw/rtl/tcpu_datapath.sv
module tcpu_datapath #(
   parameter int REG_WIDTH = tcpu_pkg::TCPU_REG_WIDTH,
   parameter int NUM_REGS  = tcpu_pkg::TCPU_NUM_REGS
) (
   input  logic              clock,
   input  logic              reset,
   input  tcpu_pkg::req_type req_item,
   input  tcpu_pkg::cmd_type cmd,
   output logic              rsp_strobe,
   output tcpu_pkg::rsp_type rsp_item
);
   import tcpu_pkg::*;

   localparam int ADDR_W = $clog2(NUM_REGS);

   req_type             req_ff;
   logic [ADDR_W-1:0]   dst_addr_ff;
   logic [ADDR_W-1:0]   src_addr_ff;
   logic [ADDR_W-1:0]   dst_addr_in;
   logic [ADDR_W-1:0]   src_addr_in;

   logic [NUM_REGS-1:0] valid_ff;
   logic [NUM_REGS-1:0] valid_in;
   logic                zero_ff;
   logic                zero_in;
   logic                carry_ff;
   logic                carry_in;
   logic                halted_ff;
   logic                halted_in;
   logic                rsp_strobe_ff;
   rsp_type             rsp_ff;
   rsp_type             rsp_in;

   logic [REG_WIDTH-1:0] rd_dst;
   logic [REG_WIDTH-1:0] rd_src;
   logic [REG_WIDTH-1:0] dst_val;
   logic [REG_WIDTH-1:0] src_val;
   logic [REG_WIDTH-1:0] imm_ext;
   logic [REG_WIDTH-1:0] add_a;
   logic [REG_WIDTH-1:0] add_b;
   logic                 add_cin;
   logic [REG_WIDTH:0]   sum_full;
   logic [REG_WIDTH-1:0] sum;
   logic                 wr_en;
   logic [REG_WIDTH-1:0] new_val;
   logic [REG_WIDTH+TCPU_OUT_W-1:0] new_wide;

   assign dst_addr_in = ADDR_W'(wrap_index(req_item.dst_index, NUM_REGS));
   assign src_addr_in = ADDR_W'(wrap_index(req_item.src_index, NUM_REGS));

   tcpu_ram #(
      .WIDTH(REG_WIDTH),
      .DEPTH(NUM_REGS)
   ) u_regfile (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (dst_addr_ff),
      .wr_data   (new_val),
      .rd_addr_a (dst_addr_in),
      .rd_data_a (rd_dst),
      .rd_addr_b (src_addr_in),
      .rd_data_b (rd_src)
   );

   // entries never written since reset read as zero
   assign dst_val = valid_ff[dst_addr_ff] ? rd_dst : '0;
   assign src_val = valid_ff[src_addr_ff] ? rd_src : '0;

   always_comb begin
      logic [REG_WIDTH+TCPU_IMM_W-1:0] imm_wide;
      imm_wide = {{REG_WIDTH{1'b0}}, req_ff.imm_value};
      imm_ext  = imm_wide[REG_WIDTH-1:0];
   end

   always_comb begin
      add_a   = dst_val;
      add_b   = src_val;
      add_cin = carry_ff;
      case (req_ff.op)
         OP_ADDI: begin
            add_b   = imm_ext;
            add_cin = 1'b0;
         end
         OP_SUB: begin
            add_b   = ~src_val;
            add_cin = 1'b1;
         end
         default: begin
            add_b = src_val;
         end
      endcase
   end

   assign sum_full = {1'b0, add_a} + {1'b0, add_b} + {{REG_WIDTH{1'b0}}, add_cin};
   assign sum      = sum_full[REG_WIDTH-1:0];

   always_comb begin
      wr_en     = 1'b0;
      new_val   = dst_val;
      zero_in   = zero_ff;
      carry_in  = carry_ff;
      halted_in = halted_ff;
      if (cmd.exec && !halted_ff) begin
         case (req_ff.op)
            OP_ADD, OP_ADDI, OP_SUB: begin
               wr_en    = 1'b1;
               new_val  = sum;
               zero_in  = (sum == '0);
               carry_in = sum_full[REG_WIDTH];
            end
            OP_MOV: begin
               wr_en   = 1'b1;
               new_val = src_val;
            end
            OP_MOVI: begin
               wr_en   = 1'b1;
               new_val = imm_ext;
            end
            OP_HALT: begin
               halted_in = 1'b1;
            end
            default: begin
               wr_en = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[dst_addr_ff] = 1'b1;
      end
   end

   assign new_wide = {{TCPU_OUT_W{1'b0}}, new_val};

   always_comb begin
      rsp_in.dst_value  = new_wide[TCPU_OUT_W-1:0];
      rsp_in.zero_flag  = zero_in;
      rsp_in.carry_flag = carry_in;
      rsp_in.halted     = halted_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         zero_ff       <= 1'b0;
         carry_ff      <= 1'b0;
         halted_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         valid_ff      <= valid_in;
         zero_ff       <= zero_in;
         carry_ff      <= carry_in;
         halted_ff     <= halted_in;
         rsp_strobe_ff <= cmd.exec;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_ff      <= req_item;
         dst_addr_ff <= dst_addr_in;
         src_addr_ff <= src_addr_in;
      end
      if (cmd.exec) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

endmodule

>>> hw/rtl/toy_cpu_execute_unit.sv
// Small execute unit: one instruction per item on a register file with zero
// and carry flags. An item is taken when start is high and busy is low; the
// register file RAM is read at that edge, the next cycle (busy high) executes
// and writes back, and the cycle after that shows the result on rsp_item with
// rsp_strobe high for that one cycle only. The receiver cannot stall, so the
// result must be captured in that cycle. busy is already low while the strobe
// is up, so a new item may be started then, with the pace set by the
// registered read of the register file followed by the execute cycle.
// Once a halt has executed, later items execute nothing but still report.
module toy_cpu_execute_unit #(
   parameter int REG_WIDTH = tcpu_pkg::TCPU_REG_WIDTH,
   parameter int NUM_REGS  = tcpu_pkg::TCPU_NUM_REGS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  tcpu_pkg::req_type req_item,
   output logic              rsp_strobe,
   output tcpu_pkg::rsp_type rsp_item
);
   import tcpu_pkg::*;

   cmd_type cmd;

   tcpu_controller u_controller (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   tcpu_datapath #(
      .REG_WIDTH(REG_WIDTH),
      .NUM_REGS (NUM_REGS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_item   (req_item),
      .cmd        (cmd),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

endmodule

>>> hw/rtl/tcpu_checker.sv
module tcpu_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_strobe,
   input tcpu_pkg::rsp_type rsp_item
);
   import tcpu_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after accept");

   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_strobe)
      else $error("result strobe missing two cycles after accept");

   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy |=> !busy)
      else $error("busy held longer than one execute cycle");

   a_strobe_after_exec: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!busy && $past(busy)))
      else $error("result strobe without a preceding execute cycle");

endmodule

bind toy_cpu_execute_unit tcpu_checker u_checker (.*);
